// File: rtl/boe_pkg.sv
// ----------------------------------------------------------------------------
// boe_pkg
// Shared types and constants for the bucket/offset value encoder.
// ----------------------------------------------------------------------------
package boe_pkg;

  localparam int unsigned TABLE_AW    = 8;
  localparam int unsigned TABLE_DEPTH = 1 << TABLE_AW;
  localparam int unsigned CODE_W      = 6;
  localparam int unsigned BASE_W      = 33;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned WORD_W      = 40;
  localparam int unsigned LEN_W       = 6;
  localparam int unsigned LEVELS_W    = 4;

  localparam logic [LEVELS_W-1:0] LEVELS_RESET = 4'd1;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_ENCODE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_FETCH,
    S_CALC,
    S_EMIT
  } boe_state_e;

  // table write request
  typedef struct packed {
    logic                en;
    logic [TABLE_AW-1:0] idx;
    logic [CODE_W-1:0]   code;
  } boe_load_t;

  // one table entry
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [BASE_W-1:0] base;
  } boe_entry_t;

endpackage

// File: rtl/boe_intf.sv
// ----------------------------------------------------------------------------
// boe_intf
// Valid/ready channels of the encoder: request, result and configuration.
// ----------------------------------------------------------------------------
interface boe_req_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [boe_pkg::TABLE_AW-1:0]  entry_index;
  logic [boe_pkg::CODE_W-1:0]    entry_code;
  logic [boe_pkg::VAL_W-1:0]     value;

  modport source (output valid, req_type, entry_index, entry_code, value, input ready);
  modport sink   (input valid, req_type, entry_index, entry_code, value, output ready);
endinterface

interface boe_res_if;
  logic                          valid;
  logic                          ready;
  logic [boe_pkg::WORD_W-1:0]    code_word;
  logic [boe_pkg::LEN_W-1:0]     code_length;
  logic [boe_pkg::TABLE_AW-1:0]  bucket;
  logic                          out_of_range;

  modport source (output valid, code_word, code_length, bucket, out_of_range, input ready);
  modport sink   (input valid, code_word, code_length, bucket, out_of_range, output ready);
endinterface

interface boe_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [boe_pkg::LEVELS_W-1:0]  levels;

  modport source (output valid, levels, input ready);
  modport sink   (input valid, levels, output ready);
endinterface

// File: rtl/bucket_offset_value_encoder.sv
// ----------------------------------------------------------------------------
// bucket_offset_value_encoder
// Table-driven bucket index plus offset encoder, binary search over a RAM.
// ----------------------------------------------------------------------------
// A load transaction writes one table entry; the block can take another
// transaction on the next cycle. An encode transaction runs a binary search
// whose depth is the effective levels setting (1..MAX_LEVELS): each search
// step is one registered read of the bucket RAM followed by one compare in
// the shared subtractor, then a final entry read and the offset computation
// produce the result. Input ready is low from acceptance of an encode until
// its result transaction completes.
// The table needs no clearing after reset; encoding before the table is
// loaded gives undefined fields.
module bucket_offset_value_encoder #(
  parameter int unsigned MAX_LEVELS = 8,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  boe_req_if.sink   req_i,
  boe_res_if.source res_o,
  boe_cfg_if.sink   cfg_i
);

  localparam int unsigned IW    = MAX_LEVELS + 1;
  localparam int unsigned LVL_W = $clog2(MAX_LEVELS + 1);
  localparam int unsigned AW    = boe_pkg::TABLE_AW;
  localparam int unsigned BW    = boe_pkg::BASE_W;

  boe_pkg::boe_state_e state_q, state_d;

  logic [boe_pkg::LEVELS_W-1:0] levels_q;
  logic [LVL_W-1:0]             eff_lvl, lvl_q;
  logic [VALUE_BITS-1:0]        v_q;
  logic [IW-1:0]                lo_q, lo_d, hi_q, hi_d, mid;
  logic [IW:0]                  mid_sum;
  logic [IW+AW-1:0]             mid_ext, lo_ext;
  logic                         done_n;
  logic                         req_fire, res_fire, enc_fire;

  boe_pkg::boe_load_t  load;
  boe_pkg::boe_entry_t rd_data;
  logic [AW-1:0]       rd_addr;
  logic [BW-1:0]       diff;
  logic                lt;

  logic [boe_pkg::CODE_W-1:0] bits;
  logic [BW-1:0]              off, mask, off_m;
  logic [63:0]                word_full;
  logic                       oor;

  logic [boe_pkg::WORD_W-1:0] word_q;
  logic [boe_pkg::LEN_W-1:0]  len_q;
  logic [AW-1:0]              bucket_q;
  logic                       oor_q;

  // configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q <= boe_pkg::LEVELS_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      levels_q <= cfg_i.levels;
    end
  end

  always_comb begin
    if (levels_q == '0) begin
      eff_lvl = LVL_W'(1);
    end else if (levels_q > MAX_LEVELS) begin
      eff_lvl = LVL_W'(MAX_LEVELS);
    end else begin
      eff_lvl = LVL_W'(levels_q);
    end
  end

  assign req_fire = req_i.valid && req_i.ready;
  assign enc_fire = req_fire && (req_i.req_type == boe_pkg::REQ_ENCODE);
  assign res_fire = res_o.valid && res_o.ready;

  assign load.en   = req_fire && (req_i.req_type == boe_pkg::REQ_LOAD);
  assign load.idx  = req_i.entry_index;
  assign load.code = req_i.entry_code;

  boe_table #(
    .VALUE_BITS(VALUE_BITS)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (load),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  boe_sub #(
    .VALUE_BITS(VALUE_BITS)
  ) u_sub (
    .a_i   (v_q),
    .b_i   (rd_data.base),
    .diff_o(diff),
    .lt_o  (lt)
  );

  // search step
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[IW:1];
  assign mid_ext = {{AW{1'b0}}, mid};
  assign lo_ext  = {{AW{1'b0}}, lo_q};

  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (lt) begin
      hi_d = mid;
    end else begin
      lo_d = mid;
    end
    done_n = (hi_d == lo_d + IW'(1));
  end

  // offset and word
  always_comb begin
    bits      = (rd_data.code == '0) ? '0 : rd_data.code - 1'b1;
    off       = lt ? '0 : diff;
    mask      = ~({BW{1'b1}} << bits);
    oor       = |(off & ~mask);
    off_m     = off & mask;
    word_full = 64'(lo_ext[AW-1:0]) | (64'(off_m) << lvl_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      boe_pkg::S_IDLE:  if (enc_fire) state_d = boe_pkg::S_READ;
      boe_pkg::S_READ:  state_d = boe_pkg::S_CMP;
      boe_pkg::S_CMP:   state_d = done_n ? boe_pkg::S_FETCH : boe_pkg::S_READ;
      boe_pkg::S_FETCH: state_d = boe_pkg::S_CALC;
      boe_pkg::S_CALC:  state_d = boe_pkg::S_EMIT;
      boe_pkg::S_EMIT:  if (res_fire) state_d = boe_pkg::S_IDLE;
      default:          state_d = boe_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_i.ready = 1'b0;
    res_o.valid = 1'b0;
    rd_addr     = mid_ext[AW-1:0];
    case (state_q)
      boe_pkg::S_IDLE:  req_i.ready = 1'b1;
      boe_pkg::S_FETCH: rd_addr = lo_ext[AW-1:0];
      boe_pkg::S_EMIT:  res_o.valid = 1'b1;
      default:          rd_addr = mid_ext[AW-1:0];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= boe_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enc_fire) begin
      v_q   <= req_i.value[VALUE_BITS-1:0];
      lvl_q <= eff_lvl;
      lo_q  <= '0;
      hi_q  <= IW'(1) << eff_lvl;
    end else if (state_q == boe_pkg::S_CMP) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
    if (state_q == boe_pkg::S_CALC) begin
      word_q   <= word_full[boe_pkg::WORD_W-1:0];
      len_q    <= boe_pkg::LEN_W'(boe_pkg::LEN_W'(lvl_q) + bits);
      bucket_q <= lo_ext[AW-1:0];
      oor_q    <= oor;
    end
  end

  assign res_o.code_word    = word_q;
  assign res_o.code_length  = len_q;
  assign res_o.bucket       = bucket_q;
  assign res_o.out_of_range = oor_q;

endmodule

// File: rtl/boe_sub.sv
// ----------------------------------------------------------------------------
// boe_sub
// Shared subtract/compare unit: value minus bucket base, with borrow.
// ----------------------------------------------------------------------------
module boe_sub #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic [VALUE_BITS-1:0]      a_i,
  input  logic [boe_pkg::BASE_W-1:0] b_i,
  output logic [boe_pkg::BASE_W-1:0] diff_o,
  output logic                       lt_o
);

  logic [boe_pkg::BASE_W:0] diff;

  assign diff   = (boe_pkg::BASE_W+1)'(a_i) - {1'b0, b_i};
  assign diff_o = diff[boe_pkg::BASE_W-1:0];
  assign lt_o   = diff[boe_pkg::BASE_W];

endmodule

// File: rtl/boe_table.sv
// ----------------------------------------------------------------------------
// boe_table
// Bucket table memory with running base accumulation on loads.
// ----------------------------------------------------------------------------
module boe_table #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  boe_pkg::boe_load_t           load_i,
  input  logic [boe_pkg::TABLE_AW-1:0] rd_addr_i,
  output boe_pkg::boe_entry_t          rd_data_o
);

  localparam logic [boe_pkg::CODE_W-1:0] CODE_MAX = boe_pkg::CODE_W'(VALUE_BITS + 1);
  localparam logic [boe_pkg::BASE_W-1:0] BASE_SAT = '1;

  boe_pkg::boe_entry_t mem_q [boe_pkg::TABLE_DEPTH];
  boe_pkg::boe_entry_t rd_q;
  logic [boe_pkg::BASE_W-1:0] rb_q, rb_d;
  logic [boe_pkg::CODE_W-1:0] code;
  logic [boe_pkg::BASE_W-1:0] base;
  logic [boe_pkg::BASE_W:0]   size, sum;

  always_comb begin
    code = (load_i.code > CODE_MAX) ? CODE_MAX : load_i.code;
    base = (load_i.idx == '0) ? '0 : rb_q;
    size = (code == '0) ? '0 : ((boe_pkg::BASE_W+1)'(1) << (code - 1'b1));
    sum  = {1'b0, base} + size;
    rb_d = sum[boe_pkg::BASE_W] ? BASE_SAT : sum[boe_pkg::BASE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rb_q <= '0;
    end else if (load_i.en) begin
      rb_q <= rb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i.en) begin
      mem_q[load_i.idx] <= '{code: code, base: base};
    end
    rd_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_q;

endmodule
